// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked in the cycle after a trigger.
`define ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) else $error(msg);

`endif

// ===== rtl/core/rv2q_pkg.sv =====
package rv2q_pkg;

  // datapath width of the CORDIC registers
  localparam int unsigned CW = 36;

  localparam logic signed [CW-1:0] Q30_ONE  = 36'sd1073741824;
  localparam logic signed [CW-1:0] Q30_GAIN = 36'sd652032874;
  localparam logic [31:0]          Q30_ONE_U = 32'd1073741824;

  // half-angle constants, Q.30 in 35 bits
  localparam logic signed [34:0] H_PI      = 35'sd3373259426;
  localparam logic signed [34:0] H_TWO_PI  = 35'sd6746518852;
  localparam logic signed [34:0] H_HALF_PI = 35'sd1686629713;

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } vec_t;

  typedef struct packed {
    vec_t        v;
    logic [63:0] n;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    vec_t               v;
    logic [31:0]        angle;
    logic               zero;
    logic signed [34:0] h;
  } rr_t;

  typedef struct packed {
    vec_t                 v;
    logic [31:0]          angle;
    logic                 zero;
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cr_t;

  typedef struct packed {
    vec_t             v;
    logic [31:0]      ms;
    logic [31:0]      angle;
    logic             zero;
    logic [31:0]      qw;
    logic [2:0][63:0] prod;
  } sc_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic [31:0]      den;
    logic             zero;
    logic [31:0]      qw;
    logic [2:0][63:0] num;
    logic [2:0][31:0] rem;
  } dv_t;

  // atan(2^-i) in Q.30
  function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
    logic signed [CW-1:0] a;
    case (i)
      0:  a = 36'sd843314856;
      1:  a = 36'sd497837829;
      2:  a = 36'sd263043837;
      3:  a = 36'sd133525159;
      4:  a = 36'sd67021687;
      5:  a = 36'sd33543516;
      6:  a = 36'sd16775851;
      7:  a = 36'sd8388437;
      8:  a = 36'sd4194283;
      9:  a = 36'sd2097149;
      31: a = 36'sd1;
      default: a = (i > 31) ? 36'sd0 : (36'sd1 <<< (30 - i));
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/rotation_vector_to_quaternion.sv =====
// Rotation vector (Q4.28 rad) to unit quaternion (Q2.30), fully pipelined.
//
// Input channel: in_valid_i / in_stall_o with rot_x_i, rot_y_i, rot_z_i.
// Output channel: out_valid_o / out_stall_i with quat_x_o .. quat_w_o.
// A beat moves on a clock edge where valid is high and stall is low.
//
// Throughput: one beat per cycle while in_stall_o is low. The path from
// input beat to output valid runs through the 32-stage square root, the
// CORDIC_STEPS-stage CORDIC and the 32-stage divider.
//
// Zero vector gives the identity (0,0,0,1.0). All outputs saturate to +-1.0.
//
// Reset clears every stage valid bit and the output/skid valid bits; data
// registers are not reset. When the receiver stalls, the output register holds
// and one more beat lands in a skid register; only then does in_stall_o
// rise and the whole pipeline freeze, so nothing is lost or repeated.
module rotation_vector_to_quaternion #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] quat_x_o,
  output logic signed [31:0] quat_y_o,
  output logic signed [31:0] quat_z_o,
  output logic signed [31:0] quat_w_o
);
  import rv2q_pkg::*;

  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned DV_STEPS = 32;

  logic en;
  logic skv_q, ov_q;
  logic in_acc;

  // pipeline advances unless the skid register is occupied
  assign en         = !skv_q;
  assign in_stall_o = skv_q;
  assign in_acc     = in_valid_i && !skv_q;

  // ---------------- stage 1: magnitudes and signs ----------------
  vec_t vec1_d, vec1_q;
  logic v1_q;

  always_comb begin
    vec1_d.mag[0] = rot_x_i[31] ? 32'(-rot_x_i) : 32'(rot_x_i);
    vec1_d.mag[1] = rot_y_i[31] ? 32'(-rot_y_i) : 32'(rot_y_i);
    vec1_d.mag[2] = rot_z_i[31] ? 32'(-rot_z_i) : 32'(rot_z_i);
    vec1_d.neg    = {rot_z_i[31], rot_y_i[31], rot_x_i[31]};
  end

  // ---------------- stage 2: squares ----------------
  logic [2:0][63:0] sqr2_q;
  vec_t vec2_q;
  logic v2_q;

  // ---------------- stage 3: sum of squares -> sqrt entry ----------------
  sq_t              sq_q [SQ_STEPS+1];
  logic [SQ_STEPS:0] sqv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      sqv_q[0] <= 1'b0;
    end else if (en) begin
      v1_q     <= in_acc;
      v2_q     <= v1_q;
      sqv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec1_q    <= vec1_d;
      vec2_q    <= vec1_q;
      sqr2_q[0] <= 64'(vec1_q.mag[0]) * 64'(vec1_q.mag[0]);
      sqr2_q[1] <= 64'(vec1_q.mag[1]) * 64'(vec1_q.mag[1]);
      sqr2_q[2] <= 64'(vec1_q.mag[2]) * 64'(vec1_q.mag[2]);
      sq_q[0].v    <= vec2_q;
      sq_q[0].n    <= sqr2_q[0] + sqr2_q[1] + sqr2_q[2];
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
    end
  end

  // ---------------- integer square root, one result bit per stage ----------------
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    sq_t         d;
    logic [34:0] r;
    logic [34:0] t;

    always_comb begin
      r = {sq_q[k].rem[32:0], sq_q[k].n[63:62]};
      t = {1'b0, sq_q[k].root, 2'b01};
      d = sq_q[k];
      d.n = {sq_q[k].n[61:0], 2'b00};
      if (r >= t) begin
        d.rem  = r - t;
        d.root = {sq_q[k].root[30:0], 1'b1};
      end else begin
        d.rem  = r;
        d.root = {sq_q[k].root[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[k+1] <= 1'b0;
      end else if (en) begin
        sqv_q[k+1] <= sqv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1] <= d;
      end
    end
  end

  // ---------------- range reduction: wrap by 2pi, then fold ----------------
  rr_t  rr_d, rr_q;
  logic rrv_q;
  logic signed [34:0] h0;

  always_comb begin
    h0         = $signed({2'b00, sq_q[SQ_STEPS].root, 1'b0});
    rr_d.v     = sq_q[SQ_STEPS].v;
    rr_d.angle = sq_q[SQ_STEPS].root;
    rr_d.zero  = (sq_q[SQ_STEPS].root == 32'd0);
    rr_d.h     = (h0 > H_PI) ? (h0 - H_TWO_PI) : h0;
  end

  cr_t                   cr_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] crv_q;
  cr_t                   cr0_d;
  logic signed [34:0]    hf;

  // fold into [-pi/2, pi/2]; the fold negates the cosine
  always_comb begin
    cr0_d.v     = rr_q.v;
    cr0_d.angle = rr_q.angle;
    cr0_d.zero  = rr_q.zero;
    cr0_d.flip  = 1'b0;
    hf          = rr_q.h;
    if (rr_q.h > H_HALF_PI) begin
      hf          = H_PI - rr_q.h;
      cr0_d.flip  = 1'b1;
    end else if (rr_q.h < -H_HALF_PI) begin
      hf          = -H_PI - rr_q.h;
      cr0_d.flip  = 1'b1;
    end
    cr0_d.x = Q30_GAIN;
    cr0_d.y = '0;
    cr0_d.z = {{(CW-35){hf[34]}}, hf};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rrv_q    <= 1'b0;
      crv_q[0] <= 1'b0;
    end else if (en) begin
      rrv_q    <= sqv_q[SQ_STEPS];
      crv_q[0] <= rrv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rr_q     <= rr_d;
      cr_q[0]  <= cr0_d;
    end
  end

  // ---------------- CORDIC, rotation mode, one micro-rotation per stage ----------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cr_t                  d;
    logic signed [CW-1:0] xv, yv, dx, dy;

    always_comb begin
      xv = cr_q[i].x;
      yv = cr_q[i].y;
      dx = yv >>> i;
      dy = xv >>> i;
      d  = cr_q[i];
      if (!cr_q[i].z[CW-1]) begin
        d.x = xv - dx;
        d.y = yv + dy;
        d.z = cr_q[i].z - atan_q30(i);
      end else begin
        d.x = xv + dx;
        d.y = yv - dy;
        d.z = cr_q[i].z + atan_q30(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        crv_q[i+1] <= 1'b0;
      end else if (en) begin
        crv_q[i+1] <= crv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cr_q[i+1] <= d;
      end
    end
  end

  // ---------------- cosine saturate, |sin|, output signs ----------------
  sc_t f_d, f_q, m_d, m_q;
  logic fv_q, mv_q;
  logic signed [CW-1:0] xf, yl;
  logic yneg;

  always_comb begin
    xf   = cr_q[CORDIC_STEPS].flip ? -cr_q[CORDIC_STEPS].x : cr_q[CORDIC_STEPS].x;
    yl   = cr_q[CORDIC_STEPS].y;
    yneg = yl[CW-1];
    f_d.v.mag = cr_q[CORDIC_STEPS].v.mag;
    f_d.v.neg = cr_q[CORDIC_STEPS].v.neg ^ {3{yneg}};
    f_d.ms    = yneg ? 32'(-yl) : 32'(yl);
    f_d.angle = cr_q[CORDIC_STEPS].angle;
    f_d.zero  = cr_q[CORDIC_STEPS].zero;
    if (xf > Q30_ONE) begin
      f_d.qw = 32'(Q30_ONE);
    end else if (xf < -Q30_ONE) begin
      f_d.qw = 32'(-Q30_ONE);
    end else begin
      f_d.qw = 32'(xf);
    end
    f_d.prod = '0;
  end

  // |r| * |sin| for each component
  always_comb begin
    m_d         = f_q;
    m_d.prod[0] = 64'(f_q.v.mag[0]) * 64'(f_q.ms);
    m_d.prod[1] = 64'(f_q.v.mag[1]) * 64'(f_q.ms);
    m_d.prod[2] = 64'(f_q.v.mag[2]) * 64'(f_q.ms);
  end

  // ---------------- products, then rounding offset into divider entry ----------------
  dv_t                dv_q [DV_STEPS+1];
  logic [DV_STEPS:0]  dvv_q;
  dv_t                dv0_d;
  logic [2:0][63:0]   numer;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      numer[j]      = m_q.prod[j] + {33'd0, m_q.angle[31:1]};
      dv0_d.rem[j]  = numer[j][63:32];
      dv0_d.num[j]  = {numer[j][31:0], 32'd0};
    end
    dv0_d.neg  = m_q.v.neg;
    dv0_d.den  = m_q.angle;
    dv0_d.zero = m_q.zero;
    dv0_d.qw   = m_q.qw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q     <= 1'b0;
      mv_q     <= 1'b0;
      dvv_q[0] <= 1'b0;
    end else if (en) begin
      fv_q     <= crv_q[CORDIC_STEPS];
      mv_q     <= fv_q;
      dvv_q[0] <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q          <= f_d;
      m_q          <= m_d;
      dv_q[0]      <= dv0_d;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  // quotient bits shift into the low end of num
  for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
    dv_t              d;
    logic [2:0][32:0] t;
    logic [2:0]       ge;

    always_comb begin
      d = dv_q[k];
      for (int j = 0; j < 3; j++) begin
        t[j]  = {dv_q[k].rem[j], dv_q[k].num[j][63]};
        ge[j] = (t[j] >= {1'b0, dv_q[k].den});
        d.rem[j] = ge[j] ? 32'(t[j] - {1'b0, dv_q[k].den}) : t[j][31:0];
        d.num[j] = {dv_q[k].num[j][62:0], ge[j]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k+1] <= 1'b0;
      end else if (en) begin
        dvv_q[k+1] <= dvv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= d;
      end
    end
  end

  // ---------------- saturate, sign, identity override ----------------
  logic [3:0][31:0] res_d, out_q, sk_q;
  logic [2:0][31:0] qv;
  logic             incoming;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qv[j] = dv_q[DV_STEPS].num[j][31:0];
      if (qv[j] > Q30_ONE_U) begin
        qv[j] = Q30_ONE_U;
      end
      res_d[j] = dv_q[DV_STEPS].neg[j] ? -qv[j] : qv[j];
    end
    res_d[3] = dv_q[DV_STEPS].qw;
    if (dv_q[DV_STEPS].zero) begin
      res_d = {Q30_ONE_U, 32'd0, 32'd0, 32'd0};
    end
  end

  assign incoming = dvv_q[DV_STEPS] && en;

  // output register plus one-entry skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      skv_q <= 1'b0;
    end else if (skv_q) begin
      if (!out_stall_i) begin
        skv_q <= 1'b0;
      end
    end else if (incoming) begin
      if (ov_q && out_stall_i) begin
        skv_q <= 1'b1;
      end else begin
        ov_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skv_q) begin
      if (!out_stall_i) begin
        out_q <= sk_q;
      end
    end else if (incoming) begin
      if (ov_q && out_stall_i) begin
        sk_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign quat_x_o    = out_q[0];
  assign quat_y_o    = out_q[1];
  assign quat_z_o    = out_q[2];
  assign quat_w_o    = out_q[3];

  // ---------------- assertions ----------------
  logic w_ok;
  assign w_ok = (quat_w_o <= 32'sd1073741824) && (quat_w_o >= -32'sd1073741824);

`include "assert_macros.svh"

  `ASSERT_CLK(a_skid_implies_out, !skv_q || ov_q, "skid holds a beat with output empty")
  `ASSERT_CLK(a_w_range, !ov_q || w_ok, "quat_w out of range")
  `ASSERT_NEXT(a_skid_drains, skv_q && !out_stall_i, !skv_q, "skid did not drain")

endmodule

// ===== sim/rv2q_checker.sv =====
module rv2q_checker #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  input  logic signed [31:0] quat_w_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QONE   = 64'sd1073741824;
  localparam longint QPI    = 64'sd3373259426;
  localparam longint QTWOPI = 64'sd6746518852;
  localparam longint QHPI   = 64'sd1686629713;
  localparam longint QGAIN  = 64'sd652032874;

  typedef struct packed {
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] qz;
    logic [31:0] qw;
  } quat_t;

  quat_t quat_q[$];
  int    n_err;

  // arctan(2^-i) in Q.30 via the alternating series in Q.62; i = 0 is a constant
  function automatic longint arctan_q30(input int i);
    longint acc;
    longint term;
    longint unsigned r;
    int e;
    int k;
    acc = 0;
    k = 0;
    if (i == 0) return 64'sd843314856;
    for (e = 62 - i; e >= 0; e -= 2 * i) begin
      term = longint'((64'd1 << e) / longint'(2 * k + 1));
      acc += (k % 2) ? -term : term;
      k++;
    end
    r = (longint'(acc) + (64'd1 << 31)) >> 32;
    return longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // magnitude product, rounded divide by the angle, saturate to 1.0, then the sign
  function automatic logic [31:0] scale_axis(input longint r, input longint s,
                                             input longint unsigned ang);
    longint unsigned mr;
    longint unsigned ms;
    longint unsigned q;
    longint v;
    mr = (r < 0) ? -r : r;
    ms = (s < 0) ? -s : s;
    q = (mr * ms + (ang >> 1)) / ang;
    if (q > QONE) q = QONE;
    v = longint'(q);
    if ((r < 0) != (s < 0)) v = -v;
    return v[31:0];
  endfunction

  function automatic quat_t rotvec_to_quat(input logic signed [31:0] vx,
                                           input logic signed [31:0] vy,
                                           input logic signed [31:0] vz);
    quat_t q;
    longint rx, ry, rz, h, cx, cy, dx, dy, cw;
    longint unsigned ax, ay, az, ang;
    logic flip;
    rx = vx; ry = vy; rz = vz;
    ax = (rx < 0) ? -rx : rx;
    ay = (ry < 0) ? -ry : ry;
    az = (rz < 0) ? -rz : rz;
    ang = int_sqrt(ax * ax + ay * ay + az * az);
    if (ang == 0) begin
      q.qx = '0; q.qy = '0; q.qz = '0;
      q.qw = QONE[31:0];
      return q;
    end
    h = longint'(ang * 2);
    while (h > QPI) h -= QTWOPI;
    flip = 1'b0;
    if (h > QHPI) begin
      h = QPI - h;
      flip = 1'b1;
    end else if (h < -QHPI) begin
      h = -QPI - h;
      flip = 1'b1;
    end
    cx = QGAIN;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 62; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (h >= 0) begin
        cx -= dx; cy += dy; h -= arctan_q30(i);
      end else begin
        cx += dx; cy -= dy; h += arctan_q30(i);
      end
    end
    if (flip) cx = -cx;
    cw = (cx > QONE) ? QONE : (cx < -QONE) ? -QONE : cx;
    q.qx = scale_axis(rx, cy, ang);
    q.qy = scale_axis(ry, cy, ang);
    q.qz = scale_axis(rz, cy, ang);
    q.qw = cw[31:0];
    return q;
  endfunction

  function automatic void cmp_field(input string nm, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch expected %0d actual %0d", $time, nm,
               $signed(exp_v), $signed(act_v));
      n_err++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    quat_t e;
    if (!rst_ni) begin
      n_err = 0;
      quat_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        quat_q.push_back(rotvec_to_quat(rot_x_i, rot_y_i, rot_z_i));
      if (out_valid_i && !out_stall_i) begin
        if (quat_q.size() == 0) begin
          $display("%0t: unexpected beat expected none actual %0d %0d %0d %0d", $time,
                   quat_x_i, quat_y_i, quat_z_i, quat_w_i);
          n_err++;
        end else begin
          e = quat_q.pop_front();
          cmp_field("quat_x", e.qx, quat_x_i);
          cmp_field("quat_y", e.qy, quat_y_i);
          cmp_field("quat_z", e.qz, quat_z_i);
          cmp_field("quat_w", e.qw, quat_w_i);
        end
      end
    end
  end

  always_comb pending_o = quat_q.size();
  always_comb errors_o = n_err + ((quat_q.size() != 0) ? 0 : 0);
endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS       = 24;
  localparam int          N_PHASE     = 630;     // random beats per phase
  localparam int          CYCLE_LIMIT = 400000;  // far above the slowest legal run
  localparam int          DRAIN       = 73 + STEPS + 30;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] rot_x, rot_y, rot_z;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
  int                 errors;
  int                 pending;
  int                 tx_idle_pct;   // sender gap rate, percent
  int                 rx_stall_pct;  // receiver stall rate, percent
  int                 cycles = 0;

  rotation_vector_to_quaternion #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .rot_x_i(rot_x), .rot_y_i(rot_y), .rot_z_i(rot_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .quat_x_o(quat_x), .quat_y_o(quat_y), .quat_z_o(quat_z), .quat_w_o(quat_w)
  );

  // watches both channels, predicts every quaternion and compares
  rv2q_checker #(.CORDIC_STEPS(STEPS)) u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .rot_x_i(rot_x), .rot_y_i(rot_y), .rot_z_i(rot_z),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .quat_x_i(quat_x), .quat_y_i(quat_y), .quat_z_i(quat_z), .quat_w_i(quat_w),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one beat. Random gaps come first; valid then stays high and the
  // payload held until an edge sees stall low. Stall is sampled at the
  // falling edge, where it is settled for the coming rising edge.
  task automatic send_vec(input logic [31:0] vx, input logic [31:0] vy,
                          input logic [31:0] vz);
    logic done;
    done = 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rot_x <= vx;
    rot_y <= vy;
    rot_z <= vz;
    while (!done) begin
      @(negedge clk);
      done = !in_stall;
      @(posedge clk);
    end
  endtask

  // random component: full range, scaled down, a single bit, or zero
  function automatic logic [31:0] rand_comp();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v = $signed(v) >>> $urandom_range(31);
      1: v = 32'd1 << $urandom_range(31);
      2: v = $signed(v) >>> $urandom_range(12, 4);
      default: ;
    endcase
    if ($urandom_range(7) == 0) v = 32'd0;
    return v;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_vec(rand_comp(), rand_comp(), rand_comp());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    rot_x = '0;
    rot_y = '0;
    rot_z = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, one LSB, field extremes, fold and wrap angles
    send_vec(32'd0, 32'd0, 32'd0);
    send_vec(32'd1, 32'd0, 32'd0);
    send_vec(32'd0, 32'hFFFF_FFFF, 32'd0);
    send_vec(32'd0, 32'd0, 32'd1);
    send_vec(32'h7FFF_FFFF, 32'd0, 32'd0);
    send_vec(32'h8000_0000, 32'd0, 32'd0);
    send_vec(32'd0, 32'h8000_0000, 32'd0);
    send_vec(32'd0, 32'd0, 32'h7FFF_FFFF);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vec(32'd843314856 >> 2, 32'd0, 32'd0);     // ~pi/4 angle
    send_vec(32'd3373259426 >> 2, 32'd0, 32'd0);    // ~pi angle, fold edge
    send_vec(32'd3373259426 >> 1, 32'd0, 32'd0);    // ~2pi angle, wrap edge
    send_vec(-(32'd3373259426 >> 1), 32'd0, 32'd0);
    send_vec(32'h1000_0000, 32'hF000_0000, 32'h1000_0000);
    send_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333);
    send_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    tx_idle_pct = 34;
    rx_stall_pct = 46;
    run_random(N_PHASE);

    // hold off until every outstanding quaternion has come back
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    tx_idle_pct = 46;
    rx_stall_pct = 34;
    run_random(N_PHASE);

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_random(N_PHASE);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rv2q_pkg.sv
rtl/core/rotation_vector_to_quaternion.sv
sim/rv2q_checker.sv
sim/testbench.sv
